// ===== sv/gap_pkg.sv =====
package gap_pkg;

  localparam int unsigned MaxNodes  = 1024;
  localparam int unsigned MaxEdges  = 4096;
  localparam int unsigned LinkDepth = 2 * MaxEdges;
  localparam int unsigned NodeW     = 10;
  localparam int unsigned LinkAw    = $clog2(LinkDepth);
  localparam int unsigned PtrW      = LinkAw + 1;
  localparam logic [PtrW-1:0] NoLink = {PtrW{1'b1}};

  typedef struct packed {
    logic             kind;
    logic [NodeW-1:0] end_a;
    logic [NodeW-1:0] end_b;
  } in_t;

  typedef struct packed {
    logic [3:0]       chunk_index;
    logic [63:0]      chunk_bits;
    logic [NodeW-1:0] point_count;
    logic             edges_dropped;
    logic             last;
  } out_t;

  // one entry per node: list head, search times, tree parent, scan cursor, cut flag
  typedef struct packed {
    logic [PtrW-1:0]  head;
    logic [NodeW-1:0] entry;
    logic [NodeW-1:0] low;
    logic [NodeW-1:0] parent;
    logic [PtrW-1:0]  scan;
    logic             cut;
  } node_rec_t;

  typedef struct packed {
    logic [PtrW-1:0]  next;
    logic [NodeW-1:0] target;
  } link_rec_t;

endpackage

// ===== sv/gap_ram.sv =====
module gap_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/graph_articulation_points.sv =====
// Cut vertices of an undirected graph. Edge beats (kind 0) append both directions
// of an edge to per-node adjacency lists; a bad endpoint or a full store drops
// the edge and raises edges_dropped for the next run. A run beat (kind 1) walks
// a depth-first search over nodes 1..node_count from a node memory and a link
// memory, then emits the cut bitmap in 64-node chunks, then runs a clearing pass
// over the node memory (also run after reset) before the next beat is taken.
module graph_articulation_points import gap_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [NodeW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ADD1  = 4'd2;
  localparam logic [3:0] S_ADD2  = 4'd3;
  localparam logic [3:0] S_OUTER = 4'd4;
  localparam logic [3:0] S_ROOT  = 4'd5;
  localparam logic [3:0] S_SYNC  = 4'd6;
  localparam logic [3:0] S_TOP   = 4'd7;
  localparam logic [3:0] S_LINK  = 4'd8;
  localparam logic [3:0] S_NBR   = 4'd9;
  localparam logic [3:0] S_POP   = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;
  localparam logic [3:0] S_EMEND = 4'd12;
  localparam logic [3:0] S_LOAD  = 4'd13;

  localparam int unsigned NodeAw = $clog2(MaxNodes);

  logic [3:0]        state_q, state_d;
  logic [NodeW-1:0]  node_count_q;
  logic [LinkAw-1:0] edge_total_q, edge_total_d;
  logic              drop_q, drop_d;
  logic [NodeW-1:0]  clock_q, clock_d;
  logic [NodeW-1:0]  count_q, count_d;
  logic [NodeW:0]    root_q, root_d;
  logic [1:0]        rc_q, rc_d;
  logic [NodeW-1:0]  cur_q, cur_d;
  node_rec_t         rec_q, rec_d;
  logic [NodeW-1:0]  ea_q, ea_d, eb_q, eb_d, w_q, w_d;
  logic [NodeW-1:0]  emit_q, emit_d;
  logic              pend_q, pend_d;
  logic [5:0]        pend_idx_q, pend_idx_d;
  logic [63:0]       bits_q, bits_d;
  logic [NodeW-1:0]  clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  logic              nd_we;
  logic [NodeAw-1:0] nd_waddr, nd_raddr;
  node_rec_t         nd_wdata, nd_rdata;
  logic              lk_we;
  logic [LinkAw-1:0] lk_waddr, lk_raddr;
  link_rec_t         lk_wdata, lk_rdata;

  gap_ram #(.Width($bits(node_rec_t)), .Depth(MaxNodes)) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (nd_we),
    .waddr_i(nd_waddr),
    .wdata_i(nd_wdata),
    .raddr_i(nd_raddr),
    .rdata_o(nd_rdata)
  );

  gap_ram #(.Width($bits(link_rec_t)), .Depth(LinkDepth)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (lk_we),
    .waddr_i(lk_waddr),
    .wdata_i(lk_wdata),
    .raddr_i(lk_raddr),
    .rdata_o(lk_rdata)
  );

  logic              in_acc;
  logic              bad_edge;
  logic [LinkAw-1:0] slot;
  logic [PtrW-1:0]   head_b;
  logic              out_free;
  logic [3:0]        chunk;
  node_rec_t         clr_rec;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign bad_edge   = (in_data_i.end_a == '0) || (in_data_i.end_b == '0) ||
                      (in_data_i.end_a > node_count_q) || (in_data_i.end_b > node_count_q) ||
                      (32'(edge_total_q) >= MaxEdges);
  assign slot       = {edge_total_q[LinkAw-2:0], 1'b0};
  assign head_b     = (eb_q == ea_q) ? {1'b0, slot} : nd_rdata.head;
  assign out_free   = !out_valid_q || out_ready_i;
  assign chunk      = 4'(emit_q[NodeW-1:6] - 4'd1);

  always_comb begin
    clr_rec      = '0;
    clr_rec.head = NoLink;
  end

  always_comb begin
    state_d      = state_q;
    edge_total_d = edge_total_q;
    drop_d       = drop_q;
    clock_d      = clock_q;
    count_d      = count_q;
    root_d       = root_q;
    rc_d         = rc_q;
    cur_d        = cur_q;
    rec_d        = rec_q;
    ea_d         = ea_q;
    eb_d         = eb_q;
    w_d          = w_q;
    emit_d       = emit_q;
    pend_d       = 1'b0;
    pend_idx_d   = pend_idx_q;
    bits_d       = bits_q;
    clr_d        = clr_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    nd_we        = 1'b0;
    nd_waddr     = cur_q;
    nd_wdata     = rec_q;
    nd_raddr     = '0;
    lk_we        = 1'b0;
    lk_waddr     = slot;
    lk_wdata     = '0;
    lk_raddr     = rec_q.scan[LinkAw-1:0];

    if (pend_q) begin
      bits_d[pend_idx_q] = nd_rdata.cut;
    end

    unique case (state_q)
      S_CLEAR: begin
        nd_we    = 1'b1;
        nd_waddr = clr_q;
        nd_wdata = clr_rec;
        clr_d    = clr_q + 1'b1;
        if (clr_q == '1) begin
          edge_total_d = '0;
          drop_d       = 1'b0;
          clock_d      = '0;
          count_d      = '0;
          state_d      = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.kind) begin
            root_d  = (NodeW+1)'(1);
            state_d = S_OUTER;
          end else if (bad_edge) begin
            drop_d = 1'b1;
          end else begin
            ea_d     = in_data_i.end_a;
            eb_d     = in_data_i.end_b;
            nd_raddr = in_data_i.end_a;
            state_d  = S_ADD1;
          end
        end
      end
      S_ADD1: begin
        lk_we           = 1'b1;
        lk_waddr        = slot;
        lk_wdata.next   = nd_rdata.head;
        lk_wdata.target = eb_q;
        nd_we           = 1'b1;
        nd_waddr        = ea_q;
        nd_wdata        = nd_rdata;
        nd_wdata.head   = {1'b0, slot};
        nd_raddr        = eb_q;
        state_d         = S_ADD2;
      end
      S_ADD2: begin
        // a self loop reads the head before the first half was written: forward it
        lk_we           = 1'b1;
        lk_waddr        = slot | LinkAw'(1);
        lk_wdata.next   = head_b;
        lk_wdata.target = ea_q;
        nd_we           = 1'b1;
        nd_waddr        = eb_q;
        nd_wdata        = nd_rdata;
        nd_wdata.head   = {1'b0, slot | LinkAw'(1)};
        edge_total_d    = edge_total_q + 1'b1;
        state_d         = S_IDLE;
      end
      S_OUTER: begin
        if (root_q > {1'b0, node_count_q}) begin
          emit_d  = '0;
          bits_d  = '0;
          state_d = S_EMIT;
        end else begin
          nd_raddr = root_q[NodeW-1:0];
          state_d  = S_ROOT;
        end
      end
      S_ROOT: begin
        if (nd_rdata.entry != '0) begin
          root_d  = root_q + 1'b1;
          state_d = S_OUTER;
        end else begin
          clock_d      = clock_q + 1'b1;
          rec_d        = nd_rdata;
          rec_d.entry  = clock_q + 1'b1;
          rec_d.low    = clock_q + 1'b1;
          rec_d.parent = '0;
          rec_d.scan   = nd_rdata.head;
          cur_d        = root_q[NodeW-1:0];
          rc_d         = '0;
          state_d      = S_SYNC;
        end
      end
      S_SYNC: begin
        nd_we   = 1'b1;
        state_d = S_TOP;
      end
      S_TOP: begin
        if (!rec_q.scan[PtrW-1]) begin
          state_d = S_LINK;
        end else begin
          nd_we = 1'b1;
          if (rec_q.parent == '0) begin
            // root finished: cut if it has two or more tree children
            if (rc_q[1]) begin
              nd_wdata.cut = 1'b1;
              count_d      = count_q + 1'b1;
            end
            root_d  = root_q + 1'b1;
            state_d = S_OUTER;
          end else begin
            nd_raddr = rec_q.parent;
            state_d  = S_POP;
          end
        end
      end
      S_LINK: begin
        rec_d.scan = lk_rdata.next;
        if (lk_rdata.target == rec_q.parent) begin
          state_d = S_TOP;
        end else begin
          w_d      = lk_rdata.target;
          nd_raddr = lk_rdata.target;
          state_d  = S_NBR;
        end
      end
      S_NBR: begin
        if (nd_rdata.entry != '0) begin
          if (nd_rdata.entry < rec_q.low) begin
            rec_d.low = nd_rdata.entry;
          end
          state_d = S_TOP;
        end else begin
          // descend: park the current node and enter the neighbour
          nd_we        = 1'b1;
          clock_d      = clock_q + 1'b1;
          rec_d        = nd_rdata;
          rec_d.entry  = clock_q + 1'b1;
          rec_d.low    = clock_q + 1'b1;
          rec_d.parent = cur_q;
          rec_d.scan   = nd_rdata.head;
          cur_d        = w_q;
          state_d      = S_SYNC;
        end
      end
      S_POP: begin
        rec_d = nd_rdata;
        if (rec_q.low < nd_rdata.low) begin
          rec_d.low = rec_q.low;
        end
        if (nd_rdata.parent != '0) begin
          if ((rec_q.low >= nd_rdata.entry) && !nd_rdata.cut) begin
            rec_d.cut = 1'b1;
            count_d   = count_q + 1'b1;
          end
        end else if (!rc_q[1]) begin
          rc_d = rc_q + 1'b1;
        end
        cur_d   = rec_q.parent;
        state_d = S_TOP;
      end
      S_EMIT: begin
        nd_raddr   = emit_q;
        pend_d     = 1'b1;
        pend_idx_d = emit_q[5:0];
        emit_d     = emit_q + 1'b1;
        if (emit_q[5:0] == 6'h3f) begin
          state_d = S_EMEND;
        end
      end
      S_EMEND: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.chunk_index     = chunk;
          out_d.chunk_bits      = bits_q;
          out_d.point_count     = count_q;
          out_d.edges_dropped   = drop_q;
          out_d.last            = (chunk == node_count_q[NodeW-1:6]);
          bits_d                = '0;
          if (chunk == node_count_q[NodeW-1:6]) begin
            clr_d   = '0;
            state_d = S_CLEAR;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      node_count_q <= '0;
      edge_total_q <= '0;
      drop_q       <= 1'b0;
      clock_q      <= '0;
      count_q      <= '0;
      root_q       <= '0;
      rc_q         <= '0;
      clr_q        <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      edge_total_q <= edge_total_d;
      drop_q       <= drop_d;
      clock_q      <= clock_d;
      count_q      <= count_d;
      root_q       <= root_d;
      rc_q         <= rc_d;
      clr_q        <= clr_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    rec_q      <= rec_d;
    ea_q       <= ea_d;
    eb_q       <= eb_d;
    w_q        <= w_d;
    emit_q     <= emit_d;
    pend_idx_q <= pend_idx_d;
    bits_q     <= bits_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.kind |=> state_q == S_OUTER)
    else $error("run beat did not start the search");

  a_root_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TOP) && rec_q.scan[PtrW-1] && (rec_q.parent == '0) |=> state_q == S_OUTER)
    else $error("finished root did not return to the outer loop");

  a_pop_parent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> rec_q.parent != '0)
    else $error("pop without a tree parent");

  a_edge_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(edge_total_q) <= MaxEdges)
    else $error("edge count above capacity");

endmodule
